>>> rtl/core/ccts_pkg.sv
// Shared widths, layout offsets and constants of the cycle count to time split block.
package ccts_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int WRAP_W     = 32;
  localparam int EXT_W      = 64;
  localparam int SECS_W     = 45;
  localparam int PART_W     = 10;
  localparam int TOTAL_W    = 64;
  localparam int MHZ_W      = 10;

  localparam logic [MHZ_W-1:0] CLOCK_MHZ_RESET = 10'd550;
  localparam logic [PART_W-1:0] PART_DIV       = 10'd1000;

  // Output tdata layout, lowest bit first.
  localparam int EXT_LSB    = 0;
  localparam int SECS_LSB   = EXT_LSB + EXT_W;
  localparam int MILLIS_LSB = SECS_LSB + SECS_W;
  localparam int MICROS_LSB = MILLIS_LSB + PART_W;
  localparam int TOTAL_LSB  = MICROS_LSB + PART_W;
  localparam int OUT_USED_W = TOTAL_LSB + TOTAL_W;
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

  // One shift per dividend bit.
  localparam int STEPS   = EXT_W;
  localparam int STEP_W  = $clog2(STEPS);

endpackage

>>> rtl/core/cycle_count_to_time_split_core.sv
// Cycle counter wrap extension and bit-serial split into seconds, millis and micros.
//
//   channel | dir | handshake              | payload (lowest bit first)
//   --------+-----+------------------------+------------------------------------------------
//   s_*     | in  | s_tvalid / s_tready    | counter_sample[31:0]
//   m_*     | out | m_tvalid / m_tready    | extended_cycles, whole_seconds, millis_part,
//           |     |                        | micros_part, total_micros, zero pad to 200 bits
//   cfg_*   | in  | cfg_wr_en              | clock_mhz[9:0]
//
// Flow: the work registers load at the accept edge, then the bit-serial divide
// runs (one dividend bit per cycle) and the result moves to the output register.
// The next item is accepted in the cycle after the result moves out of the work
// registers, while that result may still wait in the output register; no new
// item is taken while a divide is in progress.
// Reset: rst is synchronous; it clears the wrap state, the clock register
// (to 550 MHz) and all valid flags.
// Stalls: a finished result holds in the work registers until the output
// register is free; s_tready stays low meanwhile.
module cycle_count_to_time_split_core (
  input  logic                             clk,
  input  logic                             rst,
  // Config
  input  logic                             cfg_wr_en,
  input  logic [ccts_pkg::MHZ_W-1:0]       cfg_wr_data,   // clock_mhz
  // Input stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [ccts_pkg::SAMPLE_W-1:0]    s_tdata,       // counter_sample[31:0]
  // Output stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // extended_cycles[63:0], whole_seconds[108:64], millis_part[118:109],
  // micros_part[128:119], total_micros[192:129], zero pad[199:193]
  output logic [ccts_pkg::OUT_DATA_W-1:0]  m_tdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                       state;
  logic [ccts_pkg::STEP_W-1:0]      step;
  logic [ccts_pkg::MHZ_W-1:0]       clock_mhz;
  logic [ccts_pkg::SAMPLE_W-1:0]    previous_sample;
  logic [ccts_pkg::WRAP_W-1:0]      wrap_count;
  logic [ccts_pkg::WRAP_W-1:0]      wrap_next;

  // Work registers
  logic [ccts_pkg::EXT_W-1:0]       ext_rot;    // rotates back to itself after 64 steps
  logic [ccts_pkg::TOTAL_W-1:0]     total_sh;
  logic [ccts_pkg::SECS_W-1:0]      secs_sh;
  logic [ccts_pkg::MHZ_W-1:0]       rem_mhz;    // remainder of the divide by clock_mhz
  logic [ccts_pkg::PART_W-1:0]      rem_us;     // remainder of total / 1000
  logic [ccts_pkg::PART_W-1:0]      rem_ms;     // remainder of (total / 1000) / 1000

  logic [ccts_pkg::MHZ_W-1:0]       mhz_eff;
  logic [ccts_pkg::MHZ_W:0]         t0, t1, t2;
  logic                             q0, q1, q2;
  logic [ccts_pkg::MHZ_W-1:0]       rem_mhz_next;
  logic [ccts_pkg::PART_W-1:0]      rem_us_next, rem_ms_next;
  logic                             in_fire, out_load;

  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);

  // A zero clock is treated as 1 MHz so the divide is always defined.
  assign mhz_eff   = (clock_mhz == '0) ? ccts_pkg::MHZ_W'(1) : clock_mhz;
  assign wrap_next = (s_tdata < previous_sample) ? wrap_count + 1'b1 : wrap_count;

  // Three chained restoring dividers, one bit per cycle each. The first
  // produces total = ext / clock_mhz MSB first; its quotient bits feed the
  // divide by 1000, whose quotient bits feed the second divide by 1000.
  // Total micros equals floor(ext / clock_mhz), so the parts fall out as
  // total % 1000 (micros), (total / 1000) % 1000 (millis), total / 10^6 (secs).
  always_comb begin
    t0 = {rem_mhz, ext_rot[ccts_pkg::EXT_W-1]};
    q0 = (t0 >= {1'b0, mhz_eff});
    rem_mhz_next = q0 ? ccts_pkg::MHZ_W'(t0 - {1'b0, mhz_eff}) : ccts_pkg::MHZ_W'(t0);

    t1 = {rem_us, q0};
    q1 = (t1 >= {1'b0, ccts_pkg::PART_DIV});
    rem_us_next = q1 ? ccts_pkg::PART_W'(t1 - {1'b0, ccts_pkg::PART_DIV})
                     : ccts_pkg::PART_W'(t1);

    t2 = {rem_ms, q1};
    q2 = (t2 >= {1'b0, ccts_pkg::PART_DIV});
    rem_ms_next = q2 ? ccts_pkg::PART_W'(t2 - {1'b0, ccts_pkg::PART_DIV})
                     : ccts_pkg::PART_W'(t2);
  end

  // Control and wrap state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      step            <= '0;
      clock_mhz       <= ccts_pkg::CLOCK_MHZ_RESET;
      previous_sample <= '0;
      wrap_count      <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        clock_mhz <= cfg_wr_data;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            previous_sample <= s_tdata;
            wrap_count      <= wrap_next;
            step            <= '0;
            state           <= ST_RUN;
          end
        end
        ST_RUN: begin
          step <= step + 1'b1;
          if (step == ccts_pkg::STEP_W'(ccts_pkg::STEPS - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath: load on accept, shift one bit per step, hold when done
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ext_rot  <= {wrap_next, s_tdata};
      total_sh <= '0;
      secs_sh  <= '0;
      rem_mhz  <= '0;
      rem_us   <= '0;
      rem_ms   <= '0;
    end else if (state == ST_RUN) begin
      ext_rot  <= {ext_rot[ccts_pkg::EXT_W-2:0], ext_rot[ccts_pkg::EXT_W-1]};
      total_sh <= {total_sh[ccts_pkg::TOTAL_W-2:0], q0};
      secs_sh  <= {secs_sh[ccts_pkg::SECS_W-2:0], q2};
      rem_mhz  <= rem_mhz_next;
      rem_us   <= rem_us_next;
      rem_ms   <= rem_ms_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {(ccts_pkg::OUT_DATA_W - ccts_pkg::OUT_USED_W)'(0),
                  total_sh, rem_us, rem_ms, secs_sh, ext_rot};
    end
  end

endmodule

>>> rtl/core/ccts_checker.sv
// Port-level checks for the cycle count to time split core, bound into the core module.
module ccts_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [ccts_pkg::OUT_DATA_W-1:0] m_tdata
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // An accepted item keeps the block busy for the divide.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("ready right after accept");

  // Millis and micros stay below one thousand.
  a_parts_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |->
      (m_tdata[ccts_pkg::MILLIS_LSB +: ccts_pkg::PART_W] < ccts_pkg::PART_DIV) &&
      (m_tdata[ccts_pkg::MICROS_LSB +: ccts_pkg::PART_W] < ccts_pkg::PART_DIV))
    else $error("millis or micros out of range");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind cycle_count_to_time_split_core ccts_checker u_ccts_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> tb/time_split_checker.sv
// Checker for the cycle count to time split block: predicts each split and compares it.
module time_split_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [ccts_pkg::MHZ_W-1:0]      cfg_wr_data,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [ccts_pkg::SAMPLE_W-1:0]   s_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [ccts_pkg::OUT_DATA_W-1:0] m_tdata,
  output int                              fail_count,
  output int                              splits_waiting,
  output int                              splits_checked
);

  typedef struct {
    logic [ccts_pkg::EXT_W-1:0]   cycles;
    logic [ccts_pkg::SECS_W-1:0]  secs;
    logic [ccts_pkg::PART_W-1:0]  millis;
    logic [ccts_pkg::PART_W-1:0]  micros;
    logic [ccts_pkg::TOTAL_W-1:0] micros_total;
  } time_split_t;

  time_split_t                     pending_splits[$];
  logic [ccts_pkg::MHZ_W-1:0]      clock_mhz_q;
  logic [ccts_pkg::SAMPLE_W-1:0]   last_sample;
  logic [ccts_pkg::WRAP_W-1:0]     wraps;
  int                              fails;
  int                              checked;

  // Split an extended cycle count into seconds, millis and micros at the given clock.
  function automatic time_split_t split_cycles(input logic [ccts_pkg::EXT_W-1:0] cycles,
                                               input logic [ccts_pkg::MHZ_W-1:0] mhz_raw);
    time_split_t  r;
    logic [63:0]  mhz;
    logic [63:0]  per_sec;
    logic [63:0]  per_ms;
    logic [63:0]  secs;
    logic [63:0]  rest;
    logic [63:0]  ms;
    logic [63:0]  us;
    mhz     = (mhz_raw == '0) ? 64'd1 : 64'(mhz_raw);
    per_sec = mhz * 64'd1000000;
    per_ms  = mhz * 64'd1000;
    secs    = cycles / per_sec;
    rest    = cycles - secs * per_sec;
    ms      = rest / per_ms;
    rest    = rest - ms * per_ms;
    us      = rest / mhz;
    r.cycles       = cycles;
    r.secs         = secs[ccts_pkg::SECS_W-1:0];
    r.millis       = ms[ccts_pkg::PART_W-1:0];
    r.micros       = us[ccts_pkg::PART_W-1:0];
    r.micros_total = secs * 64'd1000000 + ms * 64'd1000 + us;
    return r;
  endfunction

  always @(posedge clk) begin
    time_split_t exp_s;
    time_split_t got;
    if (rst) begin
      pending_splits.delete();
      clock_mhz_q = ccts_pkg::CLOCK_MHZ_RESET;
      last_sample = '0;
      wraps       = '0;
      fails       = 0;
      checked     = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.cycles       = m_tdata[ccts_pkg::EXT_LSB +: ccts_pkg::EXT_W];
        got.secs         = m_tdata[ccts_pkg::SECS_LSB +: ccts_pkg::SECS_W];
        got.millis       = m_tdata[ccts_pkg::MILLIS_LSB +: ccts_pkg::PART_W];
        got.micros       = m_tdata[ccts_pkg::MICROS_LSB +: ccts_pkg::PART_W];
        got.micros_total = m_tdata[ccts_pkg::TOTAL_LSB +: ccts_pkg::TOTAL_W];
        if (pending_splits.size() == 0) begin
          fails++;
          $display("%0t: unexpected result, extended_cycles=%0d", $time, got.cycles);
        end else begin
          exp_s = pending_splits.pop_front();
          checked++;
          if (got.cycles !== exp_s.cycles) begin
            fails++;
            $display("%0t: extended_cycles expected %0d actual %0d",
                     $time, exp_s.cycles, got.cycles);
          end
          if (got.secs !== exp_s.secs) begin
            fails++;
            $display("%0t: whole_seconds expected %0d actual %0d",
                     $time, exp_s.secs, got.secs);
          end
          if (got.millis !== exp_s.millis) begin
            fails++;
            $display("%0t: millis_part expected %0d actual %0d",
                     $time, exp_s.millis, got.millis);
          end
          if (got.micros !== exp_s.micros) begin
            fails++;
            $display("%0t: micros_part expected %0d actual %0d",
                     $time, exp_s.micros, got.micros);
          end
          if (got.micros_total !== exp_s.micros_total) begin
            fails++;
            $display("%0t: total_micros expected %0d actual %0d",
                     $time, exp_s.micros_total, got.micros_total);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        // A drop below the last sample is one counter wrap.
        if (s_tdata < last_sample)
          wraps = wraps + 1'b1;
        last_sample = s_tdata;
        pending_splits.push_back(split_cycles({wraps, s_tdata}, clock_mhz_q));
      end
      if (cfg_wr_en)
        clock_mhz_q = cfg_wr_data;
    end
    fail_count     <= fails;
    splits_waiting <= pending_splits.size();
    splits_checked <= checked;
  end

endmodule

>>> tb/tb_cycle_count_to_time_split_core.sv
// Testbench top: drives counter samples and clock settings, and reports the verdict.
module tb_cycle_count_to_time_split_core;

  // Run bound in cycles, with a wide margin over the slowest legal run.
  localparam int CYCLE_LIMIT       = 3000000;
  localparam int SINK_HOLD_CYCLES  = 500;
  localparam int ITEMS_PER_PHASE   = 150;
  localparam int PHASES            = 10;

  logic                             clk;
  logic                             rst;
  logic                             cfg_wr_en;
  logic [ccts_pkg::MHZ_W-1:0]       cfg_wr_data;
  logic                             s_tvalid;
  logic                             s_tready;
  logic [ccts_pkg::SAMPLE_W-1:0]    s_tdata;     // counter_sample[31:0]
  logic                             m_tvalid;
  logic                             m_tready;
  // extended_cycles, whole_seconds, millis_part, micros_part, total_micros, pad
  logic [ccts_pkg::OUT_DATA_W-1:0]  m_tdata;

  int                               fail_count;
  int                               splits_waiting;
  int                               splits_checked;
  int                               cycles;
  int                               samples_sent;
  int                               settings_used;
  logic [ccts_pkg::SAMPLE_W-1:0]    last_sent;
  // Quiet stretches: neither side idles while this is set, save the receiver hold-off.
  bit                               no_idle;
  // Long receiver hold-off: requested by the stimulus, finished by the receiver.
  bit                               sink_hold_req;
  bit                               sink_hold_done;

  cycle_count_to_time_split_core uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  time_split_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .fail_count     (fail_count),
    .splits_waiting (splits_waiting),
    .splits_checked (splits_checked)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Bound the run; a hung handshake lands here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, splits_waiting);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long enough to span a whole divide.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 95) return $urandom_range(5, 70);
    return $urandom_range(100, 200);
  endfunction

  // Pick the next counter sample: random values, forward steps, small backward steps
  // (seen as wraps), values hugging both ends of the range and repeats of the last one.
  function automatic logic [ccts_pkg::SAMPLE_W-1:0] next_sample(
      input logic [ccts_pkg::SAMPLE_W-1:0] prev);
    int kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: return $urandom;
      4, 5:       return prev + $urandom_range(1, 50000000);
      6:          return prev;
      7:          return 32'hFFFF_FFFF - $urandom_range(0, 255);
      8:          return $urandom_range(0, 255);
      default:    return prev - $urandom_range(1, 1000);
    endcase
  endfunction

  // Offer one sample and hold it until accepted; return at the following falling edge
  // with tvalid still high, so back-to-back items need no re-raise.
  task automatic send_sample(input logic [ccts_pkg::SAMPLE_W-1:0] value);
    int gap;
    gap = no_idle ? 0 : idle_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    last_sent = value;
    samples_sent++;
  endtask

  // Drop tvalid and wait until every predicted result has been taken.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (splits_waiting != 0);
    @(negedge clk);
  endtask

  // Write the clock register while the block is idle.
  task automatic set_clock_mhz(input logic [ccts_pkg::MHZ_W-1:0] mhz);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mhz;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    settings_used++;
  endtask

  // Receiver: random ready pattern, quiet stretches, and one long hold-off on request.
  initial begin
    int gap;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (sink_hold_req && !sink_hold_done) begin
        m_tready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(negedge clk);
        sink_hold_done = 1'b1;
      end else if (no_idle) begin
        m_tready <= 1'b1;
        @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(negedge clk);
        gap = idle_gap();
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
  end

  // Stimulus.
  initial begin
    logic [ccts_pkg::MHZ_W-1:0]    phase_mhz;
    logic [ccts_pkg::SAMPLE_W-1:0] directed[$];
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    last_sent   = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: repeats of the previous value (no wrap), both range ends, wraps by
    // one count and by half the range, alternating bit patterns, at the reset clock.
    directed = '{32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h0000_0001, 32'hAAAA_AAAA,
                 32'h5555_5555, 32'h1234_5678};
    foreach (directed[i])
      send_sample(directed[i]);

    // Random phases, each at its own clock: slowest, fastest legal, zero (taken as one),
    // the top of the register, just above range, reset value and random picks.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       phase_mhz = 10'd1;
        1:       phase_mhz = 10'd1000;
        2:       phase_mhz = 10'd0;
        3:       phase_mhz = 10'd1023;
        4:       phase_mhz = 10'd1001;
        8:       phase_mhz = ccts_pkg::CLOCK_MHZ_RESET;
        default: phase_mhz = $urandom_range(0, 1023);
      endcase
      set_clock_mhz(phase_mhz);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Re-roll idling every 25 items; about one block in five runs flat out.
        if (n % 25 == 0)
          no_idle = ($urandom_range(0, 4) == 0);
        // Hold off the receiver while items keep coming, to back the block up.
        if (phase == 2 && n == 10)
          sink_hold_req = 1'b1;
        // Pause the sender mid-phase until everything is out.
        if (phase == 5 && n == 75)
          drain_results();
        send_sample(next_sample(last_sent));
      end
    end
    no_idle = 1'b0;
    drain_results();
    repeat (80) @(posedge clk);

    $display("Run covered %0d counter samples, %0d results checked, over %0d clock settings",
             samples_sent, splits_checked, settings_used + 1);
    $display("including zero, 1, 1000 and above-range clocks, wraps and repeated samples");
    if (fail_count == 0 && splits_waiting == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results never arrived", fail_count, splits_waiting);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
